// ===== hw/rtl/rmsl_pkg.sv =====
// shared constants, types and control bundles of the rms level smoother
// depends on nothing; every other file refers to it by scoped names
`default_nettype none

package rmsl_pkg;

    // field widths
    localparam int SAMPLE_BITS   = 16;
    localparam int MAG_BITS      = SAMPLE_BITS + 1;
    localparam int GAIN_BITS     = 4;
    localparam int SCALED_BITS   = 19;
    localparam int SUM_BITS      = 50;
    localparam int COUNT_BITS    = 13;
    localparam int MAX_FRAMES    = 4096;
    localparam int ALPHA_BITS    = 17;
    localparam int RMS_BITS      = 36;
    localparam int LEVEL_BITS    = 19;

    // square-accumulate digit loop
    localparam int ACC_DIGIT     = 5;
    localparam int ACC_DIGITS    = 4;
    localparam int MCAND_BITS    = SCALED_BITS + ACC_DIGIT * (ACC_DIGITS - 1);
    localparam int MPLIER_BITS   = ACC_DIGIT * ACC_DIGITS;
    localparam int PP_BITS       = MCAND_BITS + ACC_DIGIT;

    // divide and square root loop
    localparam int ROOT_BITS     = 41;
    localparam int ROOT_STEPS    = ROOT_BITS;
    localparam int SREM_BITS     = ROOT_BITS + 1;

    // smoothing digit loop
    localparam int SM_DIGIT      = 6;
    localparam int SM_DIGITS     = 3;
    localparam int SM_MUL_BITS   = SM_DIGIT * SM_DIGITS;
    localparam int SM_SH_BITS    = RMS_BITS + SM_DIGIT * (SM_DIGITS - 1);
    localparam int SM_ACC_BITS   = RMS_BITS + 16;
    localparam int SM_FRAC_BITS  = 16;

    localparam int STEP_BITS     = 6;

    localparam logic [ALPHA_BITS-1:0] ALPHA_ONE   = ALPHA_BITS'(65536);
    localparam logic [SM_ACC_BITS-1:0] ROUND_HALF = SM_ACC_BITS'(32768);

    // configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 17;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INPUT_GAIN   = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SMOOTH_ALPHA = CFG_INDEX_BITS'(1);
    localparam logic [GAIN_BITS-1:0]  GAIN_RESET  = GAIN_BITS'(5);
    localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = ALPHA_BITS'(4588);

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_LOAD,
        ST_ROOT,
        ST_SM_LOAD,
        ST_SMOOTH,
        ST_PUSH
    } state_t;

    // control bundles from the sequencer to the lanes
    typedef struct packed {
        logic load;
        logic zero;
        logic step;
        logic last;
        logic clear;
    } acc_ctrl_t;

    typedef struct packed {
        logic load;
        logic step;
    } root_ctrl_t;

    typedef struct packed {
        logic load;
        logic step;
        logic last;
    } sm_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rmsl_sq_acc.sv =====
// one channel lane: gain scaling, digit-serial squaring and the block sum
// depends on rmsl_pkg for widths and the acc_ctrl_t bundle
`default_nettype none

module rmsl_sq_acc (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rmsl_pkg::acc_ctrl_t                 ctrl,
    input  logic [rmsl_pkg::SAMPLE_BITS-1:0]    sample,
    input  logic [rmsl_pkg::GAIN_BITS-1:0]      gain,
    output logic [rmsl_pkg::SUM_BITS-1:0]       sum
);

    logic [rmsl_pkg::MAG_BITS-1:0]                      sample_ext;
    logic [rmsl_pkg::MAG_BITS-1:0]                      mag;
    logic [rmsl_pkg::MAG_BITS+rmsl_pkg::GAIN_BITS-1:0]  scaled_full;
    logic [rmsl_pkg::SCALED_BITS-1:0]                   scaled;
    logic [rmsl_pkg::MCAND_BITS-1:0]                    mcand_reg;
    logic [rmsl_pkg::MCAND_BITS-1:0]                    mcand_next;
    logic [rmsl_pkg::MPLIER_BITS-1:0]                   mplier_reg;
    logic [rmsl_pkg::MPLIER_BITS-1:0]                   mplier_next;
    logic [rmsl_pkg::PP_BITS-1:0]                       pp;
    logic [rmsl_pkg::SUM_BITS:0]                        sum_add;
    logic [rmsl_pkg::SUM_BITS:0]                        sum_reg;
    logic [rmsl_pkg::SUM_BITS:0]                        sum_next;

    // magnitude of the sample, then gain
    assign sample_ext  = {sample[rmsl_pkg::SAMPLE_BITS-1], sample};
    assign mag         = sample[rmsl_pkg::SAMPLE_BITS-1]
                         ? (~sample_ext + rmsl_pkg::MAG_BITS'(1)) : sample_ext;
    assign scaled_full = (rmsl_pkg::MAG_BITS + rmsl_pkg::GAIN_BITS)'(mag)
                         * (rmsl_pkg::MAG_BITS + rmsl_pkg::GAIN_BITS)'(gain);
    assign scaled      = scaled_full[rmsl_pkg::SCALED_BITS-1:0];

    // one multiplier digit per cycle
    assign pp      = rmsl_pkg::PP_BITS'(mcand_reg)
                     * rmsl_pkg::PP_BITS'(mplier_reg[rmsl_pkg::ACC_DIGIT-1:0]);
    assign sum_add = sum_reg + (rmsl_pkg::SUM_BITS + 1)'(pp);

    // operand shift registers
    always_comb
    begin
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        if (ctrl.load)
        begin
            mcand_next  = ctrl.zero ? '0 : rmsl_pkg::MCAND_BITS'(scaled);
            mplier_next = ctrl.zero ? '0 : rmsl_pkg::MPLIER_BITS'(scaled);
        end
        else if (ctrl.step)
        begin
            mcand_next  = mcand_reg << rmsl_pkg::ACC_DIGIT;
            mplier_next = mplier_reg >> rmsl_pkg::ACC_DIGIT;
        end
    end

    // sum with saturation on the last digit
    always_comb
    begin
        sum_next = sum_reg;
        if (ctrl.clear)
        begin
            sum_next = '0;
        end
        else if (ctrl.step)
        begin
            if (ctrl.last && sum_add[rmsl_pkg::SUM_BITS])
            begin
                sum_next = {1'b0, {rmsl_pkg::SUM_BITS{1'b1}}};
            end
            else
            begin
                sum_next = sum_add;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg[rmsl_pkg::SUM_BITS-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/rmsl_root.sv =====
// one channel lane: bit-serial divide of sum by frame count, fed straight
// into a one-bit-per-cycle square root; depends on rmsl_pkg
`default_nettype none

module rmsl_root (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rmsl_pkg::root_ctrl_t                ctrl,
    input  logic [rmsl_pkg::SUM_BITS-1:0]       sum,
    input  logic [rmsl_pkg::COUNT_BITS-1:0]     count,
    output logic [rmsl_pkg::RMS_BITS-1:0]       rms
);

    logic [rmsl_pkg::SUM_BITS-1:0]      dvd_reg;
    logic [rmsl_pkg::COUNT_BITS-1:0]    dvs_reg;
    logic [rmsl_pkg::COUNT_BITS-1:0]    drem_reg;
    logic                               nz_reg;
    logic [rmsl_pkg::SREM_BITS-1:0]     srem_reg;
    logic [rmsl_pkg::ROOT_BITS-1:0]     root_reg;

    logic [rmsl_pkg::COUNT_BITS:0]      r1;
    logic [rmsl_pkg::COUNT_BITS:0]      r1s;
    logic                               q1;
    logic [rmsl_pkg::COUNT_BITS:0]      r2;
    logic [rmsl_pkg::COUNT_BITS:0]      r2s;
    logic                               q2;
    logic [rmsl_pkg::SREM_BITS+1:0]     sq_rem;
    logic [rmsl_pkg::SREM_BITS+1:0]     trial;
    logic [rmsl_pkg::SREM_BITS+1:0]     sq_diff;
    logic                               ge;

    // two restoring divide steps give the next radicand bit pair
    assign r1  = {drem_reg, dvd_reg[rmsl_pkg::SUM_BITS-1]};
    assign q1  = r1 >= {1'b0, dvs_reg};
    assign r1s = q1 ? (r1 - {1'b0, dvs_reg}) : r1;
    assign r2  = {r1s[rmsl_pkg::COUNT_BITS-1:0], dvd_reg[rmsl_pkg::SUM_BITS-2]};
    assign q2  = r2 >= {1'b0, dvs_reg};
    assign r2s = q2 ? (r2 - {1'b0, dvs_reg}) : r2;

    // one square root digit
    assign sq_rem  = {srem_reg, q1 & nz_reg, q2 & nz_reg};
    assign trial   = (rmsl_pkg::SREM_BITS + 2)'({root_reg, 2'b01});
    assign ge      = sq_rem >= trial;
    assign sq_diff = sq_rem - trial;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            dvd_reg  <= sum;
            dvs_reg  <= count;
            drem_reg <= '0;
        end
        else if (ctrl.step)
        begin
            dvd_reg  <= dvd_reg << 2;
            drem_reg <= r2s[rmsl_pkg::COUNT_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nz_reg   <= 1'b0;
            srem_reg <= '0;
            root_reg <= '0;
        end
        else if (ctrl.load)
        begin
            nz_reg   <= count != '0;
            srem_reg <= '0;
            root_reg <= '0;
        end
        else if (ctrl.step)
        begin
            srem_reg <= ge ? sq_diff[rmsl_pkg::SREM_BITS-1:0]
                           : sq_rem[rmsl_pkg::SREM_BITS-1:0];
            root_reg <= {root_reg[rmsl_pkg::ROOT_BITS-2:0], ge};
        end
    end

    // saturate to the rms width
    assign rms = (|root_reg[rmsl_pkg::ROOT_BITS-1:rmsl_pkg::RMS_BITS])
                 ? {rmsl_pkg::RMS_BITS{1'b1}} : root_reg[rmsl_pkg::RMS_BITS-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/rmsl_smooth.sv =====
// one channel lane: smoothed level register and its digit-serial update
// level = (level*(1-alpha) + rms*alpha) rounded; depends on rmsl_pkg
`default_nettype none

module rmsl_smooth (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rmsl_pkg::sm_ctrl_t                  ctrl,
    input  logic [rmsl_pkg::RMS_BITS-1:0]       rms,
    input  logic [rmsl_pkg::ALPHA_BITS-1:0]     alpha,
    output logic [rmsl_pkg::LEVEL_BITS-1:0]     level
);

    logic [rmsl_pkg::ALPHA_BITS-1:0]    alpha_eff;
    logic [rmsl_pkg::ALPHA_BITS-1:0]    beta;
    logic [rmsl_pkg::SM_SH_BITS-1:0]    lvl_sh_reg;
    logic [rmsl_pkg::SM_SH_BITS-1:0]    rms_sh_reg;
    logic [rmsl_pkg::SM_MUL_BITS-1:0]   a_mul_reg;
    logic [rmsl_pkg::SM_MUL_BITS-1:0]   b_mul_reg;
    logic [rmsl_pkg::SM_ACC_BITS-1:0]   acc_reg;
    logic [rmsl_pkg::SM_ACC_BITS-1:0]   acc_next;
    logic [rmsl_pkg::SM_ACC_BITS-1:0]   pp_l;
    logic [rmsl_pkg::SM_ACC_BITS-1:0]   pp_r;
    logic [rmsl_pkg::RMS_BITS-1:0]      smooth_reg;

    // weights, alpha above one acts as one
    assign alpha_eff = alpha[rmsl_pkg::ALPHA_BITS-1] ? rmsl_pkg::ALPHA_ONE : alpha;
    assign beta      = rmsl_pkg::ALPHA_ONE - alpha_eff;

    // two partial products per digit
    assign pp_l     = rmsl_pkg::SM_ACC_BITS'(lvl_sh_reg)
                      * rmsl_pkg::SM_ACC_BITS'(b_mul_reg[rmsl_pkg::SM_DIGIT-1:0]);
    assign pp_r     = rmsl_pkg::SM_ACC_BITS'(rms_sh_reg)
                      * rmsl_pkg::SM_ACC_BITS'(a_mul_reg[rmsl_pkg::SM_DIGIT-1:0]);
    assign acc_next = acc_reg + pp_l + pp_r;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            lvl_sh_reg <= rmsl_pkg::SM_SH_BITS'(smooth_reg);
            rms_sh_reg <= rmsl_pkg::SM_SH_BITS'(rms);
            a_mul_reg  <= rmsl_pkg::SM_MUL_BITS'(alpha_eff);
            b_mul_reg  <= rmsl_pkg::SM_MUL_BITS'(beta);
            acc_reg    <= rmsl_pkg::ROUND_HALF;
        end
        else if (ctrl.step)
        begin
            lvl_sh_reg <= lvl_sh_reg << rmsl_pkg::SM_DIGIT;
            rms_sh_reg <= rms_sh_reg << rmsl_pkg::SM_DIGIT;
            a_mul_reg  <= a_mul_reg >> rmsl_pkg::SM_DIGIT;
            b_mul_reg  <= b_mul_reg >> rmsl_pkg::SM_DIGIT;
            acc_reg    <= acc_next;
        end
    end

    // smoothed level, Q20.16
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_reg <= '0;
        end
        else if (ctrl.step && ctrl.last)
        begin
            smooth_reg <= acc_next[rmsl_pkg::SM_ACC_BITS-1:rmsl_pkg::SM_FRAC_BITS];
        end
    end

    // integer part, saturated
    assign level = smooth_reg[rmsl_pkg::RMS_BITS-1]
                   ? {rmsl_pkg::LEVEL_BITS{1'b1}}
                   : smooth_reg[rmsl_pkg::RMS_BITS-2:rmsl_pkg::SM_FRAC_BITS];

endmodule

`default_nettype wire

// ===== hw/rtl/three_channel_rms_level_smoother.sv =====
// top level: sequencer, configuration registers, frame counter, output beat
// depends on rmsl_pkg, rmsl_sq_acc, rmsl_root and rmsl_smooth
`default_nettype none

// Three-channel RMS level meter. Each frame beat carries three signed
// samples; each is scaled by input_gain, squared in a 5-bit digit-serial
// multiplier and summed per channel. A frame without block_end occupies the
// square-accumulate loop for its multiplier digits (the next frame can be taken
// on the last digit; a frame arriving after idle is taken at once). A frame
// with block_end then passes a load step, the root steps in
// which a bit-serial divider hands two quotient bits per cycle to a
// one-bit-per-cycle square root, one load and the digit steps of smoothing,
// then a step to fill the level register. Frames are taken while a level
// beat waits on the output; a finished block holds in the push step until
// the output register is free. Configuration writes are accepted every cycle.
module three_channel_rms_level_smoother (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // frame channel
    input  logic                                    frame_valid,
    output logic                                    frame_stall,
    input  logic signed [rmsl_pkg::SAMPLE_BITS-1:0] sample_a,
    input  logic signed [rmsl_pkg::SAMPLE_BITS-1:0] sample_b,
    input  logic signed [rmsl_pkg::SAMPLE_BITS-1:0] sample_c,
    input  logic                                    block_end,
    // level channel
    output logic                                    level_valid,
    input  logic                                    level_stall,
    output logic [rmsl_pkg::LEVEL_BITS-1:0]         level_a,
    output logic [rmsl_pkg::LEVEL_BITS-1:0]         level_b,
    output logic [rmsl_pkg::LEVEL_BITS-1:0]         level_c,
    // configuration
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [rmsl_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [rmsl_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

    localparam logic [rmsl_pkg::STEP_BITS-1:0] ACC_LAST  =
        rmsl_pkg::STEP_BITS'(rmsl_pkg::ACC_DIGITS - 1);
    localparam logic [rmsl_pkg::STEP_BITS-1:0] ROOT_LAST =
        rmsl_pkg::STEP_BITS'(rmsl_pkg::ROOT_STEPS - 1);
    localparam logic [rmsl_pkg::STEP_BITS-1:0] SM_LAST   =
        rmsl_pkg::STEP_BITS'(rmsl_pkg::SM_DIGITS - 1);
    localparam logic [rmsl_pkg::COUNT_BITS-1:0] FRAMES_FULL =
        rmsl_pkg::COUNT_BITS'(rmsl_pkg::MAX_FRAMES);

    rmsl_pkg::state_t                   state_reg;
    rmsl_pkg::state_t                   state_next;
    logic [rmsl_pkg::STEP_BITS-1:0]     step_cnt_reg;
    logic [rmsl_pkg::STEP_BITS-1:0]     step_cnt_next;
    logic                               end_reg;
    logic                               end_next;
    logic [rmsl_pkg::COUNT_BITS-1:0]    frame_count_reg;
    logic [rmsl_pkg::COUNT_BITS-1:0]    frame_count_next;
    logic [rmsl_pkg::GAIN_BITS-1:0]     gain_reg;
    logic [rmsl_pkg::GAIN_BITS-1:0]     gain_next;
    logic [rmsl_pkg::ALPHA_BITS-1:0]    alpha_reg;
    logic [rmsl_pkg::ALPHA_BITS-1:0]    alpha_next;
    logic                               level_valid_reg;
    logic                               level_valid_next;
    logic [rmsl_pkg::LEVEL_BITS-1:0]    level_a_reg;
    logic [rmsl_pkg::LEVEL_BITS-1:0]    level_b_reg;
    logic [rmsl_pkg::LEVEL_BITS-1:0]    level_c_reg;

    logic                               accept;
    logic                               out_load;
    rmsl_pkg::acc_ctrl_t                acc_ctrl;
    rmsl_pkg::root_ctrl_t               root_ctrl;
    rmsl_pkg::sm_ctrl_t                 sm_ctrl;

    logic [rmsl_pkg::SUM_BITS-1:0]      sum_a;
    logic [rmsl_pkg::SUM_BITS-1:0]      sum_b;
    logic [rmsl_pkg::SUM_BITS-1:0]      sum_c;
    logic [rmsl_pkg::RMS_BITS-1:0]      rms_a;
    logic [rmsl_pkg::RMS_BITS-1:0]      rms_b;
    logic [rmsl_pkg::RMS_BITS-1:0]      rms_c;
    logic [rmsl_pkg::LEVEL_BITS-1:0]    lvl_a;
    logic [rmsl_pkg::LEVEL_BITS-1:0]    lvl_b;
    logic [rmsl_pkg::LEVEL_BITS-1:0]    lvl_c;

    // sequencer next state and lane controls
    always_comb
    begin
        state_next    = state_reg;
        step_cnt_next = step_cnt_reg;
        frame_stall   = 1'b1;
        out_load      = 1'b0;
        acc_ctrl      = '0;
        root_ctrl     = '0;
        sm_ctrl       = '0;
        unique case (state_reg)
            rmsl_pkg::ST_IDLE:
            begin
                frame_stall = 1'b0;
                if (frame_valid)
                begin
                    state_next    = rmsl_pkg::ST_MUL;
                    step_cnt_next = '0;
                end
            end
            rmsl_pkg::ST_MUL:
            begin
                acc_ctrl.step = 1'b1;
                if (step_cnt_reg == ACC_LAST)
                begin
                    acc_ctrl.last = 1'b1;
                    if (end_reg)
                    begin
                        state_next = rmsl_pkg::ST_LOAD;
                    end
                    else
                    begin
                        // next frame may enter on the last digit
                        frame_stall = 1'b0;
                        if (frame_valid)
                        begin
                            step_cnt_next = '0;
                        end
                        else
                        begin
                            state_next = rmsl_pkg::ST_IDLE;
                        end
                    end
                end
                else
                begin
                    step_cnt_next = step_cnt_reg + 1'b1;
                end
            end
            rmsl_pkg::ST_LOAD:
            begin
                root_ctrl.load = 1'b1;
                acc_ctrl.clear = 1'b1;
                state_next     = rmsl_pkg::ST_ROOT;
                step_cnt_next  = '0;
            end
            rmsl_pkg::ST_ROOT:
            begin
                root_ctrl.step = 1'b1;
                if (step_cnt_reg == ROOT_LAST)
                begin
                    state_next = rmsl_pkg::ST_SM_LOAD;
                end
                else
                begin
                    step_cnt_next = step_cnt_reg + 1'b1;
                end
            end
            rmsl_pkg::ST_SM_LOAD:
            begin
                sm_ctrl.load  = 1'b1;
                state_next    = rmsl_pkg::ST_SMOOTH;
                step_cnt_next = '0;
            end
            rmsl_pkg::ST_SMOOTH:
            begin
                sm_ctrl.step = 1'b1;
                if (step_cnt_reg == SM_LAST)
                begin
                    sm_ctrl.last = 1'b1;
                    state_next   = rmsl_pkg::ST_PUSH;
                end
                else
                begin
                    step_cnt_next = step_cnt_reg + 1'b1;
                end
            end
            rmsl_pkg::ST_PUSH:
            begin
                if (!level_valid_reg || !level_stall)
                begin
                    out_load   = 1'b1;
                    state_next = rmsl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rmsl_pkg::ST_IDLE;
            end
        endcase
        accept        = frame_valid && !frame_stall;
        acc_ctrl.load = accept;
        acc_ctrl.zero = frame_count_reg >= FRAMES_FULL;
    end

    // frame counter and block end flag
    always_comb
    begin
        frame_count_next = frame_count_reg;
        end_next         = end_reg;
        if (state_reg == rmsl_pkg::ST_LOAD)
        begin
            frame_count_next = '0;
        end
        else if (accept && frame_count_reg < FRAMES_FULL)
        begin
            frame_count_next = frame_count_reg + 1'b1;
        end
        if (accept)
        begin
            end_next = block_end;
        end
    end

    // configuration register decode
    always_comb
    begin
        gain_next  = gain_reg;
        alpha_next = alpha_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rmsl_pkg::CFG_INPUT_GAIN:
                begin
                    gain_next = cfg_data[rmsl_pkg::GAIN_BITS-1:0];
                end
                rmsl_pkg::CFG_SMOOTH_ALPHA:
                begin
                    alpha_next = cfg_data[rmsl_pkg::ALPHA_BITS-1:0];
                end
                default:
                begin
                    gain_next = gain_reg;
                end
            endcase
        end
    end

    // output beat valid
    always_comb
    begin
        level_valid_next = level_valid_reg;
        if (out_load)
        begin
            level_valid_next = 1'b1;
        end
        else if (level_valid_reg && !level_stall)
        begin
            level_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= rmsl_pkg::ST_IDLE;
            step_cnt_reg    <= '0;
            end_reg         <= 1'b0;
            frame_count_reg <= '0;
            gain_reg        <= rmsl_pkg::GAIN_RESET;
            alpha_reg       <= rmsl_pkg::ALPHA_RESET;
            level_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            step_cnt_reg    <= step_cnt_next;
            end_reg         <= end_next;
            frame_count_reg <= frame_count_next;
            gain_reg        <= gain_next;
            alpha_reg       <= alpha_next;
            level_valid_reg <= level_valid_next;
        end
    end

    // level payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            level_a_reg <= lvl_a;
            level_b_reg <= lvl_b;
            level_c_reg <= lvl_c;
        end
    end

    assign cfg_ready   = 1'b1;
    assign level_valid = level_valid_reg;
    assign level_a     = level_a_reg;
    assign level_b     = level_b_reg;
    assign level_c     = level_c_reg;

    // channel lanes
    rmsl_sq_acc u_acc_a (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (acc_ctrl),
        .sample (sample_a),
        .gain   (gain_reg),
        .sum    (sum_a)
    );

    rmsl_sq_acc u_acc_b (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (acc_ctrl),
        .sample (sample_b),
        .gain   (gain_reg),
        .sum    (sum_b)
    );

    rmsl_sq_acc u_acc_c (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (acc_ctrl),
        .sample (sample_c),
        .gain   (gain_reg),
        .sum    (sum_c)
    );

    rmsl_root u_root_a (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (root_ctrl),
        .sum    (sum_a),
        .count  (frame_count_reg),
        .rms    (rms_a)
    );

    rmsl_root u_root_b (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (root_ctrl),
        .sum    (sum_b),
        .count  (frame_count_reg),
        .rms    (rms_b)
    );

    rmsl_root u_root_c (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (root_ctrl),
        .sum    (sum_c),
        .count  (frame_count_reg),
        .rms    (rms_c)
    );

    rmsl_smooth u_smooth_a (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (sm_ctrl),
        .rms    (rms_a),
        .alpha  (alpha_reg),
        .level  (lvl_a)
    );

    rmsl_smooth u_smooth_b (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (sm_ctrl),
        .rms    (rms_b),
        .alpha  (alpha_reg),
        .level  (lvl_b)
    );

    rmsl_smooth u_smooth_c (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (sm_ctrl),
        .rms    (rms_c),
        .alpha  (alpha_reg),
        .level  (lvl_c)
    );

`ifndef NO_ASSERTIONS
    // frame counter never passes the block capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        frame_count_reg <= FRAMES_FULL)
        else $error("frame counter beyond capacity");

    // a closing block always has at least one frame
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == rmsl_pkg::ST_LOAD |-> frame_count_reg != '0)
        else $error("block closed with no frames");

    // root loop stays within its step count
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == rmsl_pkg::ST_ROOT |-> step_cnt_reg <= ROOT_LAST)
        else $error("root step counter out of range");

    // a push with a free output slot yields a level beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rmsl_pkg::ST_PUSH && (!level_valid_reg || !level_stall))
        |=> level_valid_reg)
        else $error("level beat lost at push");
`endif

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// self-checking testbench for three_channel_rms_level_smoother
// depends on rmsl_pkg and the smoother top level; needs nothing else

module testbench;

    localparam realtime CLK_HALF      = 6;
    localparam int      RESET_CYCLES  = 10;
    localparam int      CYCLE_LIMIT   = 1_000_000;
    localparam int      SETTLE_CYCLES = 64;
    localparam int      HOLD_CYCLES   = 400;
    localparam int      CHUNK_FRAMES  = 670;

    localparam logic [63:0] SUM_LIMIT   = (64'd1 << rmsl_pkg::SUM_BITS) - 64'd1;
    localparam logic [63:0] RMS_LIMIT   = (64'd1 << rmsl_pkg::RMS_BITS) - 64'd1;
    localparam logic [63:0] LEVEL_LIMIT = (64'd1 << rmsl_pkg::LEVEL_BITS) - 64'd1;
    localparam logic [63:0] UNITY       = 64'(rmsl_pkg::ALPHA_ONE);

    typedef struct {
        logic signed [rmsl_pkg::SAMPLE_BITS-1:0] a;
        logic signed [rmsl_pkg::SAMPLE_BITS-1:0] b;
        logic signed [rmsl_pkg::SAMPLE_BITS-1:0] c;
        logic                                    last;
    } frame_t;

    typedef struct packed {
        logic [rmsl_pkg::LEVEL_BITS-1:0] a;
        logic [rmsl_pkg::LEVEL_BITS-1:0] b;
        logic [rmsl_pkg::LEVEL_BITS-1:0] c;
    } levels_t;

    typedef enum int {
        PACE_SEND_LIGHT,
        PACE_RECV_LIGHT,
        PACE_FREE
    } pace_t;

    // dut ports
    logic                                    clk         = 1'b0;
    logic                                    rst_n       = 1'b0;
    logic                                    frame_valid = 1'b0;
    logic                                    frame_stall;
    logic signed [rmsl_pkg::SAMPLE_BITS-1:0] sample_a    = '0;
    logic signed [rmsl_pkg::SAMPLE_BITS-1:0] sample_b    = '0;
    logic signed [rmsl_pkg::SAMPLE_BITS-1:0] sample_c    = '0;
    logic                                    block_end   = 1'b0;
    logic                                    level_valid;
    logic                                    level_stall = 1'b1;
    logic [rmsl_pkg::LEVEL_BITS-1:0]         level_a;
    logic [rmsl_pkg::LEVEL_BITS-1:0]         level_b;
    logic [rmsl_pkg::LEVEL_BITS-1:0]         level_c;
    logic                                    cfg_valid   = 1'b0;
    logic                                    cfg_ready;
    logic [rmsl_pkg::CFG_INDEX_BITS-1:0]     cfg_index   = '0;
    logic [rmsl_pkg::CFG_DATA_BITS-1:0]      cfg_data    = '0;

    // stimulus and scoreboard
    frame_t  frames_to_send[$];
    levels_t levels_due[$];
    pace_t   pace            = PACE_SEND_LIGHT;
    logic    frame_accepted  = 1'b0;
    int      frames_queued   = 0;
    int      frames_taken    = 0;
    int      levels_seen     = 0;
    int      cfg_writes_done = 0;
    int      failures        = 0;
    int      cycle_count     = 0;
    int      hold_requests   = 0;
    int      holds_started   = 0;
    int      hold_left       = 0;

    // meter state as the block should hold it
    logic [rmsl_pkg::GAIN_BITS-1:0]  gain_now        = rmsl_pkg::GAIN_RESET;
    logic [rmsl_pkg::ALPHA_BITS-1:0] alpha_now       = rmsl_pkg::ALPHA_RESET;
    logic [63:0]                     energy[3]       = '{default: 64'd0};
    logic [63:0]                     smooth_lvl[3]   = '{default: 64'd0};
    int                              frames_in_block = 0;

    three_channel_rms_level_smoother i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .sample_a    (sample_a),
        .sample_b    (sample_b),
        .sample_c    (sample_c),
        .block_end   (block_end),
        .level_valid (level_valid),
        .level_stall (level_stall),
        .level_a     (level_a),
        .level_b     (level_b),
        .level_c     (level_c),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    function automatic logic [63:0] magnitude(logic signed [rmsl_pkg::SAMPLE_BITS-1:0] s);
        int v;
        v = s;
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] accumulate(logic [63:0] acc, logic [63:0] scaled);
        logic [63:0] total;
        total = acc + scaled * scaled;
        return (total > SUM_LIMIT) ? SUM_LIMIT : total;
    endfunction

    // floor of sqrt(mean square) with 16 fraction bits, digit by digit
    function automatic logic [63:0] block_root(logic [63:0] total, int frames);
        logic [63:0] whole;
        logic [63:0] frac;
        logic [63:0] root;
        logic [63:0] rest;
        logic [63:0] trial;
        logic [83:0] radicand;
        if (frames == 0)
            return 64'd0;
        whole    = total / 64'(frames);
        frac     = ((total % 64'(frames)) << 32) / 64'(frames);
        radicand = {whole[51:0], frac[31:0]};
        root     = 64'd0;
        rest     = 64'd0;
        for (int k = 41; k >= 0; k--)
        begin
            rest  = (rest << 2) | 64'(radicand[2*k +: 2]);
            trial = (root << 2) | 64'd1;
            if (rest >= trial)
            begin
                rest = rest - trial;
                root = (root << 1) | 64'd1;
            end
            else
                root = root << 1;
        end
        return (root > RMS_LIMIT) ? RMS_LIMIT : root;
    endfunction

    // exponential step toward the block rms, rounded half up
    function automatic logic [63:0] smooth_toward(logic [63:0] lvl, logic [63:0] rms,
                                                  logic [rmsl_pkg::ALPHA_BITS-1:0] alpha);
        logic [63:0] w;
        w = (64'(alpha) > UNITY) ? UNITY : 64'(alpha);
        return (lvl * (UNITY - w) + rms * w + 64'd32768) >> 16;
    endfunction

    function automatic logic [rmsl_pkg::LEVEL_BITS-1:0] level_of(logic [63:0] lvl);
        logic [63:0] whole;
        whole = lvl >> 16;
        return rmsl_pkg::LEVEL_BITS'((whole > LEVEL_LIMIT) ? LEVEL_LIMIT : whole);
    endfunction

    // fold one accepted frame into the expected meter state
    function automatic void absorb_frame(frame_t f);
        logic [63:0] scaled[3];
        levels_t     beat;
        scaled[0] = magnitude(f.a) * 64'(gain_now);
        scaled[1] = magnitude(f.b) * 64'(gain_now);
        scaled[2] = magnitude(f.c) * 64'(gain_now);
        // a full block ignores further frames but still closes
        if (frames_in_block < rmsl_pkg::MAX_FRAMES)
        begin
            for (int ch = 0; ch < 3; ch++)
                energy[ch] = accumulate(energy[ch], scaled[ch]);
            frames_in_block++;
        end
        if (f.last)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                smooth_lvl[ch] = smooth_toward(smooth_lvl[ch],
                                               block_root(energy[ch], frames_in_block),
                                               alpha_now);
                energy[ch] = 64'd0;
            end
            frames_in_block = 0;
            beat.a = level_of(smooth_lvl[0]);
            beat.b = level_of(smooth_lvl[1]);
            beat.c = level_of(smooth_lvl[2]);
            levels_due.insert(levels_due.size(), beat);
        end
    endfunction

    function automatic void check_field(string field, logic [rmsl_pkg::LEVEL_BITS-1:0] want,
                                        logic [rmsl_pkg::LEVEL_BITS-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            failures++;
        end
    endfunction

    function automatic int send_idle_pct();
        case (pace)
            PACE_SEND_LIGHT: return 24;
            PACE_RECV_LIGHT: return 47;
            default:         return 0;
        endcase
    endfunction

    function automatic int recv_idle_pct();
        case (pace)
            PACE_SEND_LIGHT: return 47;
            PACE_RECV_LIGHT: return 24;
            default:         return 0;
        endcase
    endfunction

    function automatic void queue_frame(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                                        logic last);
        frame_t f;
        f.a    = a;
        f.b    = b;
        f.c    = c;
        f.last = last;
        frames_to_send.insert(frames_to_send.size(), f);
        frames_queued++;
    endfunction

    // full-scale values, near-silence and plain noise
    function automatic logic [15:0] pick_sample();
        int roll;
        roll = $urandom_range(9);
        if (roll == 0)
            return 16'h8000;
        if (roll == 1)
            return 16'h7fff;
        if (roll == 2)
            return 16'($urandom_range(4)) - 16'd2;
        if (roll == 3)
            return 16'($urandom_range(600)) - 16'd300;
        return 16'($urandom);
    endfunction

    // measurement blocks of mostly short length, a few long ones
    function automatic void queue_random_blocks(int count);
        int left;
        int len;
        int roll;
        left = count;
        while (left > 0)
        begin
            roll = $urandom_range(9);
            if (roll < 6)
                len = $urandom_range(4, 1);
            else if (roll < 9)
                len = $urandom_range(32, 5);
            else
                len = $urandom_range(120, 33);
            if (len > left)
                len = left;
            for (int i = 1; i <= len; i++)
                queue_frame(pick_sample(), pick_sample(), pick_sample(), i == len);
            left -= len;
        end
    endfunction

    task automatic wait_until_idle();
        do
            @(negedge clk);
        while (frames_taken != frames_queued || levels_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(logic [rmsl_pkg::CFG_INDEX_BITS-1:0] index,
                                  logic [rmsl_pkg::CFG_DATA_BITS-1:0] value);
        int target;
        target = cfg_writes_done + 1;
        @(negedge clk);
        cfg_index <= index;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(negedge clk);
        while (cfg_writes_done != target);
        cfg_valid <= 1'b0;
    endtask

    // gain lives in the low bits; the rest of the data word is don't-care noise
    task automatic write_gain(int gain);
        write_register(rmsl_pkg::CFG_INPUT_GAIN,
                       {13'($urandom), rmsl_pkg::GAIN_BITS'(gain)});
    endtask

    task automatic write_random_config();
        write_gain($urandom_range(15, 1));
        write_register(rmsl_pkg::CFG_SMOOTH_ALPHA, 17'($urandom_range(65536)));
    endtask

    // frame driver: next beat only once the current one is taken
    always @(negedge clk)
    begin
        frame_t f;
        if (!frame_valid || frame_accepted)
        begin
            if (frames_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct())
            begin
                f = frames_to_send.pop_front();
                sample_a    <= f.a;
                sample_b    <= f.b;
                sample_c    <= f.c;
                block_end   <= f.last;
                frame_valid <= 1'b1;
            end
            else
                frame_valid <= 1'b0;
        end
    end

    // level receiver: random stalls plus long hold-offs on request
    always @(negedge clk)
    begin
        if (hold_requests != holds_started)
        begin
            holds_started = hold_requests;
            hold_left     = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            level_stall <= 1'b1;
        end
        else
            level_stall <= ($urandom_range(99) < recv_idle_pct());
    end

    // monitor: frames into the predictor, levels against the oldest expectation
    always @(posedge clk)
    begin
        frame_t  f;
        levels_t want;
        if (rst_n)
        begin
            frame_accepted <= frame_valid && !frame_stall;
            if (frame_valid && !frame_stall)
            begin
                f.a    = sample_a;
                f.b    = sample_b;
                f.c    = sample_c;
                f.last = block_end;
                absorb_frame(f);
                frames_taken++;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    rmsl_pkg::CFG_INPUT_GAIN:   gain_now  = cfg_data[rmsl_pkg::GAIN_BITS-1:0];
                    rmsl_pkg::CFG_SMOOTH_ALPHA: alpha_now = cfg_data[rmsl_pkg::ALPHA_BITS-1:0];
                    default: ;
                endcase
                cfg_writes_done++;
            end
            if (level_valid && !level_stall)
            begin
                if (levels_due.size() == 0)
                begin
                    $error("level beat with no closed block pending: a=%0d b=%0d c=%0d",
                           level_a, level_b, level_c);
                    failures++;
                end
                else
                begin
                    want = levels_due.pop_front();
                    check_field("level_a", want.a, level_a);
                    check_field("level_b", want.b, level_b);
                    check_field("level_c", want.c, level_c);
                    levels_seen++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("run stopped after %0d cycles with %0d level beats outstanding",
                     cycle_count, levels_due.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: full-scale and zero samples
        @(posedge clk);
        queue_frame(16'h7fff, 16'h8000, 16'h0000, 1'b1);
        queue_frame(16'hffff, 16'h0001, 16'h0000, 1'b0);
        queue_frame(16'h8000, 16'h8000, 16'h8000, 1'b0);
        queue_frame(16'h7fff, 16'h7fff, 16'h7fff, 1'b1);
        wait_until_idle();

        // top gain, alpha of one: level jumps straight to the block rms
        write_gain(15);
        write_register(rmsl_pkg::CFG_SMOOTH_ALPHA, rmsl_pkg::ALPHA_ONE);
        queue_frame(16'h8000, 16'h7fff, 16'h0001, 1'b1);
        queue_frame(16'h8000, 16'h8000, 16'h8000, 1'b1);
        queue_frame(16'h5555, 16'haaaa, 16'h0000, 1'b0);
        queue_frame(16'haaaa, 16'h5555, 16'hffff, 1'b1);
        wait_until_idle();

        // gain of zero squares everything to zero
        write_gain(0);
        queue_frame(16'h8000, 16'h7fff, 16'h1234, 1'b0);
        queue_frame(16'h7fff, 16'h8000, 16'hedcb, 1'b1);
        wait_until_idle();

        // alpha of zero freezes the levels
        write_gain(1);
        write_register(rmsl_pkg::CFG_SMOOTH_ALPHA, 17'd0);
        queue_frame(16'h8000, 16'h0000, 16'h7fff, 1'b1);
        queue_frame(16'h0001, 16'hffff, 16'h4000, 1'b1);
        wait_until_idle();

        // alpha above one is clamped to one
        write_register(rmsl_pkg::CFG_SMOOTH_ALPHA, 17'h1ffff);
        queue_frame(16'h8000, 16'h8000, 16'h7fff, 1'b0);
        queue_frame(16'h0000, 16'h7fff, 16'hc000, 1'b1);
        wait_until_idle();
        write_register(rmsl_pkg::CFG_SMOOTH_ALPHA, 17'h10001);
        queue_frame(16'h0100, 16'hff00, 16'h8001, 1'b1);
        wait_until_idle();

        // random blocks: sender light, receiver heavy
        write_gain(5);
        write_register(rmsl_pkg::CFG_SMOOTH_ALPHA, rmsl_pkg::ALPHA_RESET);
        pace = PACE_SEND_LIGHT;
        queue_random_blocks(CHUNK_FRAMES);
        wait_until_idle();

        // random blocks: sender heavy, receiver light
        write_random_config();
        pace = PACE_RECV_LIGHT;
        queue_random_blocks(CHUNK_FRAMES);
        wait_until_idle();

        // back-to-back single-frame blocks against a long output hold
        write_random_config();
        pace = PACE_FREE;
        @(posedge clk);
        hold_requests++;
        for (int i = 0; i < 20; i++)
            queue_frame(pick_sample(), pick_sample(), pick_sample(), 1'b1);
        queue_random_blocks(CHUNK_FRAMES - 20);
        wait_until_idle();

        $display("run covered %0d frames, %0d level beats and %0d register writes",
                 frames_taken, levels_seen, cfg_writes_done);
        $display("including zero gain, clamped alpha and a %0d-cycle output hold",
                 HOLD_CYCLES);
        if (failures == 0 && levels_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
